// ----- sv/pss_pkg.sv -----
// shared types and constants of the pid position servo step
// no dependencies; imported by pss_state, pss_power, the top level and the testbench
package pss_pkg;

    localparam int MAX_ANGLE    = 180;
    localparam int WINDOW_LEN   = 5;
    localparam int FULL_DUTY    = 4096;
    localparam int INT_WINDOW   = 10;
    localparam int STABLE_LIMIT = 5;

    // field widths
    localparam int ANGLE_W = 8;
    localparam int ERR_W   = ANGLE_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int GAIN_W  = 16;
    localparam int DUTY_W  = 13;
    localparam int INT_W   = 32;
    localparam int CNT_W   = 3;

    // derived datapath widths
    localparam int SUM_W     = DIFF_W + $clog2(WINDOW_LEN);
    localparam int NUM_W     = GAIN_W + SUM_W;
    localparam int P_W       = GAIN_W + ERR_W + 1;
    localparam int PWR_W     = INT_W + 2;

    // derivative divide by a constant through a reciprocal multiply
    localparam int DIV      = WINDOW_LEN * 100;
    localparam int DIV_SH   = $clog2(DIV);
    localparam int RECIP_SH = NUM_W + DIV_SH;
    localparam int RECIP_W  = NUM_W + 1;
    localparam int Q_W      = NUM_W - DIV_SH + 1;
    localparam int MULT_W   = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(DIV) - 64'd1) / 64'(DIV));

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = GAIN_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE = 3'd4;

    typedef struct packed {
        logic signed [ERR_W-1:0] target;
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_i;
        logic [GAIN_W-1:0]       gain_d;
        logic                    enable;
    } t_cfg;

    // result of the state stage, handed to the power pipeline
    typedef struct packed {
        logic                    en;
        logic                    settled;
        logic signed [ERR_W-1:0] err;
        logic                    sum_neg;
        logic [SUM_W-1:0]        sum_mag;
        logic signed [INT_W-1:0] integ;
    } t_s1;

endpackage

// ----- sv/pss_state.sv -----
// loop state of the servo step: error, speed window, integral, stable count
// depends on pss_pkg; feeds pss_power through a registered t_s1 stage
module pss_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_angle,
    input  pss_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output pss_pkg::t_s1      o_s1
);
    import pss_pkg::*;

    localparam logic signed [ERR_W-1:0] TGT_MIN = '1;
    localparam logic signed [ERR_W-1:0] TGT_MAX = ERR_W'(MAX_ANGLE);
    localparam logic signed [ERR_W-1:0] IW_POS  = ERR_W'(INT_WINDOW);
    localparam logic signed [ERR_W-1:0] IW_NEG  = -ERR_W'(INT_WINDOW);
    localparam logic signed [ERR_W-1:0] ONE_POS = ERR_W'(1);
    localparam logic signed [ERR_W-1:0] ONE_NEG = '1;

    logic [ANGLE_W-1:0]        r_prev_angle, n_prev_angle;
    logic signed [ERR_W-1:0]   r_prev_err, n_prev_err;
    logic signed [DIFF_W-1:0]  r_win [WINDOW_LEN];
    logic signed [DIFF_W-1:0]  n_win [WINDOW_LEN];
    logic signed [SUM_W-1:0]   r_wsum, n_wsum;
    logic signed [INT_W-1:0]   r_int, n_int;
    logic [CNT_W-1:0]          r_stable, n_stable;
    logic                      r_valid;
    t_s1                       r_s1, n_s1;

    logic                      ld;
    logic [ANGLE_W-1:0]        angle;
    logic signed [ERR_W-1:0]   tgt;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   da;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SUM_W-1:0]   sum;
    logic signed [P_W-1:0]     prod_i;
    logic signed [INT_W:0]     int_wide;
    logic signed [INT_W-1:0]   int_upd;
    logic [CNT_W-1:0]          cnt_upd;
    logic                      settled;
    logic                      restart;

    assign ld      = i_valid && o_ready;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s1    = r_s1;

    always_comb begin
        angle = (i_angle > ANGLE_W'(MAX_ANGLE)) ? ANGLE_W'(MAX_ANGLE) : i_angle;

        if (i_cfg.target < TGT_MIN) begin
            tgt = TGT_MIN;
        end else if (i_cfg.target > TGT_MAX) begin
            tgt = TGT_MAX;
        end else begin
            tgt = i_cfg.target;
        end
        err  = tgt - $signed({1'b0, angle});
        diff = DIFF_W'(err) - DIFF_W'(r_prev_err);
        // running window sum: drop the oldest difference, add the newest
        sum  = r_wsum - SUM_W'(r_win[0]) + SUM_W'(diff);

        // integrate only inside the small error band, clear outside it and at zero error
        prod_i   = P_W'($signed({1'b0, i_cfg.gain_i})) * P_W'(err);
        int_wide = (INT_W + 1)'(r_int) + (INT_W + 1)'(prod_i);
        if (int_wide[INT_W] != int_wide[INT_W-1]) begin
            int_upd = int_wide[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                      : {1'b0, {(INT_W-1){1'b1}}};
        end else begin
            int_upd = int_wide[INT_W-1:0];
        end
        if (err == '0 || err >= IW_POS || err <= IW_NEG) begin
            int_upd = '0;
        end

        da = $signed({1'b0, angle}) - $signed({1'b0, r_prev_angle});
        cnt_upd = (da >= ONE_NEG && da <= ONE_POS) ? r_stable + CNT_W'(1) : r_stable;
        settled = i_cfg.enable && (cnt_upd > CNT_W'(STABLE_LIMIT));
        restart = !i_cfg.enable || settled;

        for (int k = 0; k < WINDOW_LEN - 1; k++) begin
            n_win[k] = restart ? '0 : r_win[k+1];
        end
        n_win[WINDOW_LEN-1] = restart ? '0 : diff;
        n_wsum       = restart ? '0 : sum;
        n_int        = restart ? '0 : int_upd;
        n_stable     = restart ? '0 : cnt_upd;
        n_prev_angle = restart ? '0 : angle;
        n_prev_err   = restart ? '0 : err;

        n_s1.en      = i_cfg.enable;
        n_s1.settled = settled;
        n_s1.err     = err;
        n_s1.sum_neg = sum[SUM_W-1];
        n_s1.sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        n_s1.integ   = int_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_prev_angle <= '0;
            r_prev_err   <= '0;
            r_wsum       <= '0;
            r_int        <= '0;
            r_stable     <= '0;
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (ld) begin
                r_prev_angle <= n_prev_angle;
                r_prev_err   <= n_prev_err;
                r_wsum       <= n_wsum;
                r_int        <= n_int;
                r_stable     <= n_stable;
                for (int k = 0; k < WINDOW_LEN; k++) begin
                    r_win[k] <= n_win[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_s1 <= n_s1;
        end
    end

`ifndef NO_ASSERTIONS
    a_settle_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_s1.settled |-> r_s1.en)
        else $error("settled flagged on a disabled request");

    a_stable_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stable <= CNT_W'(STABLE_LIMIT))
        else $error("stable count passed its limit");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld && restart |=> r_int == '0 && r_stable == '0 && r_wsum == '0)
        else $error("move state not cleared on restart");
`endif

endmodule

// ----- sv/pss_power.sv -----
// power pipeline: pid terms, derivative divide, sum and h-bridge duty
// depends on pss_pkg; takes t_s1 from pss_state, holds the result register
module pss_power (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  pss_pkg::t_s1          i_s1,
    input  pss_pkg::t_cfg         i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [12:0]           o_drive_a,
    output logic [12:0]           o_drive_b,
    output logic                  o_settled
);
    import pss_pkg::*;

    localparam logic [DUTY_W-1:0] FULL = DUTY_W'(FULL_DUTY);

    typedef struct packed {
        logic                    en;
        logic                    settled;
        logic signed [P_W-1:0]   p;
        logic [NUM_W-1:0]        dmag;
        logic                    neg;
        logic signed [INT_W-1:0] integ;
    } t_sa;

    typedef struct packed {
        logic                    en;
        logic                    settled;
        logic signed [P_W-1:0]   p;
        logic [Q_W-1:0]          q;
        logic                    neg;
        logic signed [INT_W-1:0] integ;
    } t_sb;

    typedef struct packed {
        logic                    en;
        logic                    settled;
        logic signed [PWR_W-1:0] pwr;
    } t_sc;

    t_sa r_a, n_a;
    t_sb r_b, n_b;
    t_sc r_c, n_c;
    logic r_va, r_vb, r_vc, r_vo;
    logic rdy_a, rdy_b, rdy_c, rdy_o;
    logic [DUTY_W-1:0] r_da, r_db, n_da, n_db;
    logic r_set, n_set;

    logic [MULT_W-1:0]       prod_q;
    logic signed [PWR_W-1:0] dq;
    logic [PWR_W-1:0]        mag;
    logic [DUTY_W-1:0]       duty;
    logic                    pos;

    assign rdy_o   = !r_vo || i_ready;
    assign rdy_c   = !r_vc || rdy_o;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vo;
    assign o_drive_a = r_da;
    assign o_drive_b = r_db;
    assign o_settled = r_set;

    always_comb begin
        n_a.en      = i_s1.en;
        n_a.settled = i_s1.settled;
        n_a.p       = P_W'($signed({1'b0, i_cfg.gain_p})) * P_W'(i_s1.err);
        n_a.dmag    = NUM_W'(i_cfg.gain_d) * NUM_W'(i_s1.sum_mag);
        n_a.neg     = i_s1.sum_neg;
        n_a.integ   = i_s1.integ;

        // exact floor divide of the magnitude, sign restored in the next stage
        prod_q      = MULT_W'(r_a.dmag) * MULT_W'(RECIP);
        n_b.en      = r_a.en;
        n_b.settled = r_a.settled;
        n_b.p       = r_a.p;
        n_b.q       = Q_W'(prod_q >> RECIP_SH);
        n_b.neg     = r_a.neg;
        n_b.integ   = r_a.integ;

        dq          = $signed(PWR_W'(r_b.q));
        if (r_b.neg) begin
            dq = -dq;
        end
        n_c.en      = r_b.en;
        n_c.settled = r_b.settled;
        n_c.pwr     = PWR_W'(r_b.p) + dq + PWR_W'(r_b.integ);

        mag  = r_c.pwr[PWR_W-1] ? PWR_W'(-r_c.pwr) : PWR_W'(r_c.pwr);
        duty = (mag >= PWR_W'(FULL_DUTY)) ? '0 : FULL - DUTY_W'(mag);
        pos  = !r_c.pwr[PWR_W-1] && (r_c.pwr != '0);
        if (!r_c.en) begin
            n_da = '0;
            n_db = '0;
        end else if (pos) begin
            n_da = duty;
            n_db = FULL;
        end else begin
            n_da = FULL;
            n_db = duty;
        end
        n_set = r_c.en && r_c.settled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
            if (rdy_o) begin
                r_vo <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a <= n_a;
        end
        if (rdy_b) begin
            r_b <= n_b;
        end
        if (rdy_c) begin
            r_c <= n_c;
        end
        if (rdy_o) begin
            r_da  <= n_da;
            r_db  <= n_db;
            r_set <= n_set;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_side_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> (r_da == FULL || r_db == FULL
                  || (r_da == '0 && r_db == '0 && !r_set)))
        else $error("neither bridge side fully on for an enabled result");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc && !rdy_c |=> r_vc && $stable(r_c.pwr))
        else $error("stalled power stage lost its value");
`endif

endmodule

// ----- sv/pid_position_servo_step.sv -----
// top level of the pid position servo step: config registers, input register
// depends on pss_pkg, pss_state and pss_power
//
//  channel   direction  handshake            payload
//  sample    in         i_valid / o_ready    i_measured_angle
//  result    out        o_valid / i_ready    o_drive_a, o_drive_b, o_settled
//  config    in         i_cfg_we             i_cfg_addr, i_cfg_data
//
// one sample is taken every cycle while the result side does not stall; a request
// passes the input register, state stage, three math stages and result register in turn
// the state loop closes through the integral multiply-accumulate
// synchronous active-low reset clears config, move state and all valid flags
// a stalled result backs up stage by stage; empty stages keep filling
module pid_position_servo_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_measured_angle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [12:0] o_drive_a,
    output logic [12:0] o_drive_b,
    output logic        o_settled,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);
    import pss_pkg::*;

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic [ANGLE_W-1:0] r_in_angle;
    logic               st_ready;
    logic               s1_valid;
    logic               pw_ready;
    t_s1                s1;

    assign o_ready = !r_in_valid || st_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TARGET: r_cfg.target <= i_cfg_data[ERR_W-1:0];
                CFG_GAIN_P: r_cfg.gain_p <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I: r_cfg.gain_i <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D: r_cfg.gain_d <= i_cfg_data[GAIN_W-1:0];
                CFG_ENABLE: r_cfg.enable <= i_cfg_data[0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_angle <= i_measured_angle;
        end
    end

    pss_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (st_ready),
        .i_angle (r_in_angle),
        .i_cfg   (r_cfg),
        .o_valid (s1_valid),
        .i_ready (pw_ready),
        .o_s1    (s1)
    );

    pss_power u_power (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s1_valid),
        .o_ready   (pw_ready),
        .i_s1      (s1),
        .i_cfg     (r_cfg),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_drive_a (o_drive_a),
        .o_drive_b (o_drive_b),
        .o_settled (o_settled)
    );

endmodule

// ----- dv/pid_position_servo_step_tb.sv -----
// testbench of the pid position servo step: directed and random angle streams
// checked against an in-bench prediction of the pid loop; depends on pss_pkg
// and pid_position_servo_step
module pid_position_servo_step_tb;
    import pss_pkg::*;

    localparam int PIPE_LAT     = 6;
    localparam int RANDOM_ITEMS = 1030;
    localparam int BAND_ITEMS   = 150;
    localparam longint INT_HI   = 64'sd2147483647;
    localparam longint INT_LO   = -64'sd2147483648;

    typedef struct {
        logic [DUTY_W-1:0] drive_a;
        logic [DUTY_W-1:0] drive_b;
        logic              settled;
    } t_drive;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [ANGLE_W-1:0]    i_measured_angle = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [DUTY_W-1:0]     o_drive_a;
    logic [DUTY_W-1:0]     o_drive_b;
    logic                  o_settled;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pid_position_servo_step dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_measured_angle (i_measured_angle),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_drive_a        (o_drive_a),
        .o_drive_b        (o_drive_b),
        .o_settled        (o_settled),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the config registers
    logic signed [ERR_W-1:0] cfg_target = '0;
    logic [GAIN_W-1:0]       cfg_gain_p = '0;
    logic [GAIN_W-1:0]       cfg_gain_i = '0;
    logic [GAIN_W-1:0]       cfg_gain_d = '0;
    logic                    cfg_enable = 1'b0;

    // shadow of the move state
    int     last_angle;
    int     last_err;
    int     speed_win[WINDOW_LEN];
    longint integ_acc;
    int     stable_ticks;

    t_drive pending_drive[$];
    int     fail_count = 0;
    bit     calm = 1'b0;
    int     sent_count = 0;

    function automatic void start_move();
        last_angle   = 0;
        last_err     = 0;
        integ_acc    = 0;
        stable_ticks = 0;
        foreach (speed_win[k]) speed_win[k] = 0;
    endfunction

    function automatic t_drive predict_drive(input logic [ANGLE_W-1:0] meas);
        int     ang, tgt, err, step_diff;
        longint wsum, pwr, mag, duty;
        t_drive r;
        ang = int'(meas);
        if (ang > MAX_ANGLE) ang = MAX_ANGLE;
        if (!cfg_enable) begin
            start_move();
            r.drive_a = '0;
            r.drive_b = '0;
            r.settled = 1'b0;
            return r;
        end
        tgt = int'(cfg_target);
        if (tgt < -1) tgt = -1;
        if (tgt > MAX_ANGLE) tgt = MAX_ANGLE;
        err = tgt - ang;

        for (int k = 0; k + 1 < WINDOW_LEN; k++) speed_win[k] = speed_win[k + 1];
        speed_win[WINDOW_LEN - 1] = err - last_err;
        wsum = 0;
        foreach (speed_win[k]) wsum += speed_win[k];

        // integral only runs inside the small error band
        if ((err >= 1 && err < INT_WINDOW) || (err <= -1 && err > -INT_WINDOW)) begin
            integ_acc += longint'(err) * longint'(cfg_gain_i);
            if (integ_acc > INT_HI) integ_acc = INT_HI;
            if (integ_acc < INT_LO) integ_acc = INT_LO;
        end else begin
            integ_acc = 0;
        end

        pwr = longint'(cfg_gain_p) * err
            + (longint'(cfg_gain_d) * wsum) / longint'(WINDOW_LEN * 100)
            + integ_acc;
        mag  = (pwr < 0) ? -pwr : pwr;
        duty = FULL_DUTY - mag;
        if (duty < 0) duty = 0;
        if (pwr > 0) begin
            r.drive_a = DUTY_W'(duty);
            r.drive_b = DUTY_W'(FULL_DUTY);
        end else begin
            r.drive_a = DUTY_W'(FULL_DUTY);
            r.drive_b = DUTY_W'(duty);
        end

        step_diff = ang - last_angle;
        if (step_diff >= -1 && step_diff <= 1) stable_ticks++;
        last_angle = ang;
        last_err   = err;
        r.settled  = 1'b0;
        if (stable_ticks > STABLE_LIMIT) begin
            r.settled = 1'b1;
            start_move();
        end
        return r;
    endfunction

    initial start_move();

    // predict on each accepted request, track config writes, check results
    always @(posedge i_clk) begin
        t_drive exp_drive;
        if (i_rst_n) begin
            if (i_valid && o_ready) pending_drive.push_back(predict_drive(i_measured_angle));
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TARGET: cfg_target = i_cfg_data[ERR_W-1:0];
                    CFG_GAIN_P: cfg_gain_p = i_cfg_data;
                    CFG_GAIN_I: cfg_gain_i = i_cfg_data;
                    CFG_GAIN_D: cfg_gain_d = i_cfg_data;
                    CFG_ENABLE: cfg_enable = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                if (pending_drive.size() == 0) begin
                    fail_count++;
                    $error("result with no request outstanding");
                end else begin
                    exp_drive = pending_drive.pop_front();
                    if (o_drive_a !== exp_drive.drive_a) begin
                        fail_count++;
                        $error("drive_a: expected %0d, got %0d", exp_drive.drive_a, o_drive_a);
                    end
                    if (o_drive_b !== exp_drive.drive_b) begin
                        fail_count++;
                        $error("drive_b: expected %0d, got %0d", exp_drive.drive_b, o_drive_b);
                    end
                    if (o_settled !== exp_drive.settled) begin
                        fail_count++;
                        $error("settled: expected %0d, got %0d", exp_drive.settled, o_settled);
                    end
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
    end

    task automatic send_angle(input logic [ANGLE_W-1:0] a);
        if (!calm && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 9);
        end
        i_valid          <= 1'b1;
        i_measured_angle <= a;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_count++;
    endtask

    // stop requesting and wait until every result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input int target, input int kp, input int ki, input int kd,
                               input bit en);
        // bits above the register width are don't-care, so fill them at random
        write_reg(CFG_TARGET, {7'($urandom), 9'(target)});
        write_reg(CFG_GAIN_P, 16'(kp));
        write_reg(CFG_GAIN_I, 16'(ki));
        write_reg(CFG_GAIN_D, 16'(kd));
        write_reg(CFG_ENABLE, {15'($urandom), en});
    endtask

    task automatic write_unused_regs();
        for (int a = int'(CFG_ENABLE) + 1; a < (1 << CFG_ADDR_W); a++)
            write_reg(CFG_ADDR_W'(a), 16'($urandom));
    endtask

    task automatic test_disabled_after_reset();
        send_angle(8'd0);
        send_angle(8'd255);
        send_angle(8'd180);
        drain_results();
        write_unused_regs();
        send_angle(8'd90);
    endtask

    task automatic test_extremes();
        drain_results();
        load_config(180, 65535, 65535, 65535, 1'b1);
        send_angle(8'd0);
        send_angle(8'd255);
        send_angle(8'd181);
        drain_results();
        // target below range clamps to -1
        load_config(-256, 4095, 40, 65535, 1'b1);
        send_angle(8'd0);
        send_angle(8'd180);
        send_angle(8'd0);
        drain_results();
        load_config(255, 100, 10, 65535, 1'b1);
        send_angle(8'd180);
        send_angle(8'd0);
        drain_results();
        load_config(181, 0, 0, 0, 1'b1);
        send_angle(8'd170);
    endtask

    task automatic test_settle_and_restart();
        drain_results();
        // disabling for one sample clears the move state
        write_reg(CFG_ENABLE, 16'd0);
        send_angle(8'd45);
        drain_results();
        load_config(90, 20, 5, 300, 1'b1);
        repeat (7) send_angle(8'd90);
        send_angle(8'd91);
    endtask

    task automatic test_integral_band();
        drain_results();
        calm = 1'b1;
        load_config(100, 0, 65535, 0, 1'b1);
        // steps of two keep the stable count still while the error stays in band
        for (int j = 0; j < BAND_ITEMS; j++) send_angle((j % 2) ? 8'd93 : 8'd91);
        send_angle(8'd100);
        for (int j = 0; j < BAND_ITEMS; j++) send_angle((j % 2) ? 8'd107 : 8'd109);
        drain_results();
        calm = 1'b0;
    endtask

    function automatic int pick_gain();
        case ($urandom_range(4))
            0:       return 0;
            1:       return $urandom_range(255);
            2:       return $urandom_range(4095);
            3:       return 65535;
            default: return $urandom_range(65535);
        endcase
    endfunction

    function automatic int pick_target();
        int edges[7] = '{-256, -2, -1, 0, 180, 181, 255};
        case ($urandom_range(5))
            0:       return edges[$urandom_range(6)];
            1:       return int'($urandom_range(511)) - 256;
            default: return $urandom_range(MAX_ANGLE);
        endcase
    endfunction

    task automatic test_random_moves();
        int start_count, target, goal, plant, n, phase;
        start_count = sent_count;
        plant = 0;
        phase = 0;
        while (sent_count - start_count < RANDOM_ITEMS) begin
            drain_results();
            target = pick_target();
            load_config(target, pick_gain(), pick_gain(), pick_gain(), $urandom_range(99) < 88);
            if ($urandom_range(9) == 0) write_unused_regs();
            goal = (target < 0) ? 0 : (target > MAX_ANGLE) ? MAX_ANGLE : target;
            if ($urandom_range(1)) plant = $urandom_range(MAX_ANGLE);
            n = $urandom_range(10, 60);
            for (int j = 0; j < n; j++) begin
                if ($urandom_range(99) < 12) begin
                    send_angle(8'($urandom_range(255)));
                end else begin
                    if (plant < goal) plant += $urandom_range(3);
                    else if (plant > goal) plant -= $urandom_range(3);
                    if ($urandom_range(99) < 20) plant += int'($urandom_range(2)) - 1;
                    if (plant < 0) plant = 0;
                    if (plant > MAX_ANGLE) plant = MAX_ANGLE;
                    send_angle(8'(plant));
                end
                // hold requests off until the pipeline is empty once mid-move
                if (phase == 3 && j == n / 2) drain_results();
            end
            phase++;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_after_reset();
        test_extremes();
        test_settle_and_restart();
        test_integral_band();
        test_random_moves();
        drain_results();
        if (fail_count == 0) begin
            $display("pid_position_servo_step regression: pass");
        end else begin
            $display("pid_position_servo_step regression: fail");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("pid_position_servo_step regression: fail");
        $finish;
    end

endmodule
